@@ sv/ordbk_pkg.sv @@
// ----------------------------------------------------------------------------
// Order book table package
// Sizes, table entry types and command codes shared by the order book modules.
// ----------------------------------------------------------------------------
package ordbk_pkg;

  localparam int N_ORD  = 1024;
  localparam int ORD_AW = $clog2(N_ORD);
  localparam int N_LPS  = 256;
  localparam int LPS_AW = $clog2(N_LPS);
  localparam int N_LVL  = 2 * N_LPS;
  localparam int LVL_AW = LPS_AW + 1;
  localparam int CNT_W  = ORD_AW + 1;

  localparam logic [CNT_W-1:0] ORD_CNT = CNT_W'(N_ORD);
  localparam logic [CNT_W-1:0] LPS_CNT = CNT_W'(N_LPS);
  localparam logic [CNT_W-1:0] LVL_CNT = CNT_W'(N_LVL);

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_MODIFY = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic               valid;
    logic [31:0]        key;
    logic               side;
    logic signed [31:0] price;
    logic [31:0]        qty;
  } ord_ent_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] price;
    logic [31:0]        total;
    logic [ORD_AW-1:0]  head;
    logic [ORD_AW-1:0]  tail;
  } lvl_ent_t;

  typedef struct packed {
    logic              we;
    logic [ORD_AW-1:0] addr;
    ord_ent_t          data;
  } ord_wr_t;

  typedef struct packed {
    logic              we;
    logic [LVL_AW-1:0] addr;
    lvl_ent_t          data;
  } lvl_wr_t;

  typedef struct packed {
    logic              we;
    logic [ORD_AW-1:0] addr;
    logic [ORD_AW-1:0] data;
  } lnk_wr_t;

endpackage

@@ sv/limit_order_book_table_top.sv @@
// ----------------------------------------------------------------------------
// Order book table, top level
// Resting order table with per-side price levels and time-ordered queues.
// ----------------------------------------------------------------------------
// After reset the block clears its tables and holds busy high. A query
// request only scans the level table for its result; add, cancel and modify
// requests first search the order table and, unless the id of a cancel or
// modify is unknown, the side's level entries. The block returns to idle
// after each result. The order table is searched one entry per cycle for
// the id, the side's 256 level entries one per cycle for the addressed levels,
// and all 512 level entries one per cycle for the best prices and the depth.
// A request is taken when start_i is high and busy_o is low. Its result is
// shown for exactly one cycle with done_o high and cannot be held off by the
// receiver.
module limit_order_book_table_top import ordbk_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         cmd_i,
  input  logic [31:0]        order_id_i,
  input  logic               side_i,
  input  logic signed [31:0] price_i,
  input  logic [31:0]        quantity_i,
  output logic               done_o,
  output logic               accepted_o,
  output logic               bid_valid_o,
  output logic signed [31:0] bid_px_o,
  output logic               ask_valid_o,
  output logic signed [31:0] ask_px_o,
  output logic               spread_valid_o,
  output logic signed [31:0] spread_ticks_o,
  output logic [31:0]        level_depth_o
);

  logic [ORD_AW-1:0] ord_raddr;
  ord_ent_t          ord_rdata;
  ord_wr_t           ord_wr;
  logic [LVL_AW-1:0] lvl_raddr;
  lvl_ent_t          lvl_rdata;
  lvl_wr_t           lvl_wr;
  logic [ORD_AW-1:0] lnk_raddr;
  logic [ORD_AW-1:0] nxt_rdata;
  logic [ORD_AW-1:0] prv_rdata;
  lnk_wr_t           nxt_wr;
  lnk_wr_t           prv_wr;

  ordbk_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .cmd_i          (cmd_i),
    .order_id_i     (order_id_i),
    .side_i         (side_i),
    .price_i        (price_i),
    .quantity_i     (quantity_i),
    .busy_o         (busy_o),
    .done_o         (done_o),
    .accepted_o     (accepted_o),
    .bid_valid_o    (bid_valid_o),
    .bid_px_o       (bid_px_o),
    .ask_valid_o    (ask_valid_o),
    .ask_px_o       (ask_px_o),
    .spread_valid_o (spread_valid_o),
    .spread_ticks_o (spread_ticks_o),
    .level_depth_o  (level_depth_o),
    .ord_raddr_o    (ord_raddr),
    .ord_rdata_i    (ord_rdata),
    .ord_wr_o       (ord_wr),
    .lvl_raddr_o    (lvl_raddr),
    .lvl_rdata_i    (lvl_rdata),
    .lvl_wr_o       (lvl_wr),
    .lnk_raddr_o    (lnk_raddr),
    .nxt_rdata_i    (nxt_rdata),
    .prv_rdata_i    (prv_rdata),
    .nxt_wr_o       (nxt_wr),
    .prv_wr_o       (prv_wr)
  );

  ordbk_store u_store (
    .clk_i       (clk_i),
    .ord_raddr_i (ord_raddr),
    .ord_rdata_o (ord_rdata),
    .ord_wr_i    (ord_wr),
    .lvl_raddr_i (lvl_raddr),
    .lvl_rdata_o (lvl_rdata),
    .lvl_wr_i    (lvl_wr),
    .lnk_raddr_i (lnk_raddr),
    .nxt_rdata_o (nxt_rdata),
    .prv_rdata_o (prv_rdata),
    .nxt_wr_i    (nxt_wr),
    .prv_wr_i    (prv_wr)
  );

endmodule

@@ sv/ordbk_store.sv @@
// ----------------------------------------------------------------------------
// Order book storage
// Order table, level table and the forward and backward link tables, each
// with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ordbk_store import ordbk_pkg::*; (
  input  logic              clk_i,
  input  logic [ORD_AW-1:0] ord_raddr_i,
  output ord_ent_t          ord_rdata_o,
  input  ord_wr_t           ord_wr_i,
  input  logic [LVL_AW-1:0] lvl_raddr_i,
  output lvl_ent_t          lvl_rdata_o,
  input  lvl_wr_t           lvl_wr_i,
  input  logic [ORD_AW-1:0] lnk_raddr_i,
  output logic [ORD_AW-1:0] nxt_rdata_o,
  output logic [ORD_AW-1:0] prv_rdata_o,
  input  lnk_wr_t           nxt_wr_i,
  input  lnk_wr_t           prv_wr_i
);

  ord_ent_t          ord_mem [N_ORD];
  lvl_ent_t          lvl_mem [N_LVL];
  logic [ORD_AW-1:0] nxt_mem [N_ORD];
  logic [ORD_AW-1:0] prv_mem [N_ORD];

  always_ff @(posedge clk_i) begin
    if (ord_wr_i.we) begin
      ord_mem[ord_wr_i.addr] <= ord_wr_i.data;
    end
    ord_rdata_o <= ord_mem[ord_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (lvl_wr_i.we) begin
      lvl_mem[lvl_wr_i.addr] <= lvl_wr_i.data;
    end
    lvl_rdata_o <= lvl_mem[lvl_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (nxt_wr_i.we) begin
      nxt_mem[nxt_wr_i.addr] <= nxt_wr_i.data;
    end
    nxt_rdata_o <= nxt_mem[lnk_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (prv_wr_i.we) begin
      prv_mem[prv_wr_i.addr] <= prv_wr_i.data;
    end
    prv_rdata_o <= prv_mem[lnk_raddr_i];
  end

endmodule

@@ sv/ordbk_ctrl.sv @@
// ----------------------------------------------------------------------------
// Order book sequencer
// Scans the tables one entry per cycle, decides each request, relinks the
// level queues and computes best prices, spread and level depth.
// ----------------------------------------------------------------------------
module ordbk_ctrl import ordbk_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [1:0]         cmd_i,
  input  logic [31:0]        order_id_i,
  input  logic               side_i,
  input  logic signed [31:0] price_i,
  input  logic [31:0]        quantity_i,
  output logic               busy_o,
  output logic               done_o,
  output logic               accepted_o,
  output logic               bid_valid_o,
  output logic signed [31:0] bid_px_o,
  output logic               ask_valid_o,
  output logic signed [31:0] ask_px_o,
  output logic               spread_valid_o,
  output logic signed [31:0] spread_ticks_o,
  output logic [31:0]        level_depth_o,
  output logic [ORD_AW-1:0]  ord_raddr_o,
  input  ord_ent_t           ord_rdata_i,
  output ord_wr_t            ord_wr_o,
  output logic [LVL_AW-1:0]  lvl_raddr_o,
  input  lvl_ent_t           lvl_rdata_i,
  output lvl_wr_t            lvl_wr_o,
  output logic [ORD_AW-1:0]  lnk_raddr_o,
  input  logic [ORD_AW-1:0]  nxt_rdata_i,
  input  logic [ORD_AW-1:0]  prv_rdata_i,
  output lnk_wr_t            nxt_wr_o,
  output lnk_wr_t            prv_wr_o
);

  typedef enum logic [11:0] {
    S_CLEAR  = 12'b000000000001,
    S_IDLE   = 12'b000000000010,
    S_OSCAN  = 12'b000000000100,
    S_LSCAN  = 12'b000000001000,
    S_DECIDE = 12'b000000010000,
    S_UNLINK = 12'b000000100000,
    S_APPEND = 12'b000001000000,
    S_WB_B   = 12'b000010000000,
    S_WB_A   = 12'b000100000000,
    S_FSCAN  = 12'b001000000000,
    S_SPREAD = 12'b010000000000,
    S_RESP   = 12'b100000000000
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               pv_q, pv_d;
  logic [ORD_AW-1:0]  pidx_q, pidx_d;

  cmd_e               cmd_q, cmd_d;
  logic [31:0]        id_q, id_d;
  logic               side_q, side_d;
  logic signed [31:0] price_q, price_d;
  logic [31:0]        qty_q, qty_d;

  logic               hit_q, hit_d;
  logic [ORD_AW-1:0]  oidx_q, oidx_d;
  ord_ent_t           oe_q, oe_d;
  logic               offnd_q, offnd_d;
  logic [ORD_AW-1:0]  ofidx_q, ofidx_d;

  lvl_ent_t           la_q, la_d, lb_q, lb_d;
  logic [LVL_AW-1:0]  laidx_q, laidx_d, lbidx_q, lbidx_d, lfidx_q, lfidx_d;
  logic               lafnd_q, lafnd_d, lbfnd_q, lbfnd_d, lffnd_q, lffnd_d;

  logic               ok_q, ok_d;
  logic               dside_q, dside_d;
  logic signed [31:0] dprice_q, dprice_d;
  logic               uen_q, uen_d, usa_q, usa_d, apen_q, apen_d;
  logic               wa_q, wa_d, wb_q, wb_d, ow_q, ow_d;
  ord_ent_t           owd_q, owd_d;

  logic               bv_q, bv_d, av_q, av_d;
  logic signed [31:0] bid_q, bid_d, ask_q, ask_d;
  logic [31:0]        depth_q, depth_d;

  logic               racc_q, racc_d, rbv_q, rbv_d, rav_q, rav_d, rsv_q, rsv_d;
  logic signed [31:0] rbid_q, rbid_d, rask_q, rask_d, rspr_q, rspr_d;
  logic [31:0]        rdep_q, rdep_d;

  logic [CNT_W-1:0]   scan_len;
  logic               scan_more;
  logic               scan_end;
  logic               lsc_side;

  always_comb begin
    unique case (state_q)
      S_CLEAR, S_OSCAN: scan_len = ORD_CNT;
      S_LSCAN:          scan_len = LPS_CNT;
      default:          scan_len = LVL_CNT;
    endcase
  end

  assign scan_more   = cnt_q < scan_len;
  assign scan_end    = !scan_more && !pv_q;
  assign lsc_side    = (cmd_q == CMD_ADD) ? side_q : oe_q.side;
  assign ord_raddr_o = cnt_q[ORD_AW-1:0];
  assign lvl_raddr_o = (state_q == S_LSCAN) ? {lsc_side, cnt_q[LPS_AW-1:0]}
                                            : cnt_q[LVL_AW-1:0];
  assign lnk_raddr_o = oidx_q;
  assign busy_o      = state_q != S_IDLE;
  assign done_o      = state_q == S_RESP;

  always_comb begin
    logic               same;
    logic [31:0]        other;
    lvl_ent_t           xl;
    logic [LVL_AW-1:0]  fidx;
    logic signed [32:0] diff;

    state_d = state_q;
    cnt_d = cnt_q; pv_d = 1'b0; pidx_d = cnt_q[ORD_AW-1:0];
    cmd_d = cmd_q; id_d = id_q; side_d = side_q; price_d = price_q; qty_d = qty_q;
    hit_d = hit_q; oidx_d = oidx_q; oe_d = oe_q; offnd_d = offnd_q; ofidx_d = ofidx_q;
    la_d = la_q; lb_d = lb_q; laidx_d = laidx_q; lbidx_d = lbidx_q; lfidx_d = lfidx_q;
    lafnd_d = lafnd_q; lbfnd_d = lbfnd_q; lffnd_d = lffnd_q;
    ok_d = ok_q; dside_d = dside_q; dprice_d = dprice_q;
    uen_d = uen_q; usa_d = usa_q; apen_d = apen_q;
    wa_d = wa_q; wb_d = wb_q; ow_d = ow_q; owd_d = owd_q;
    bv_d = bv_q; av_d = av_q; bid_d = bid_q; ask_d = ask_q; depth_d = depth_q;
    racc_d = racc_q; rbv_d = rbv_q; rav_d = rav_q; rsv_d = rsv_q;
    rbid_d = rbid_q; rask_d = rask_q; rspr_d = rspr_q; rdep_d = rdep_q;
    ord_wr_o = '0; lvl_wr_o = '0; nxt_wr_o = '0; prv_wr_o = '0;
    same = price_q == oe_q.price;
    other = '0;
    xl = usa_q ? la_q : lb_q;
    fidx = {1'b0, pidx_q[LVL_AW-2:0]};
    diff = '0;

    if (scan_more) begin
      cnt_d = cnt_q + 1'b1;
      pv_d  = 1'b1;
    end

    unique case (state_q)
      S_CLEAR: begin
        pv_d = 1'b0;
        ord_wr_o.we   = 1'b1;
        ord_wr_o.addr = cnt_q[ORD_AW-1:0];
        lvl_wr_o.we   = cnt_q < LVL_CNT;
        lvl_wr_o.addr = cnt_q[LVL_AW-1:0];
        if (cnt_q == ORD_CNT - 1'b1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        cnt_d = '0;
        pv_d  = 1'b0;
        if (start_i) begin
          cmd_d = cmd_e'(cmd_i); id_d = order_id_i; side_d = side_i;
          price_d = price_i; qty_d = quantity_i;
          hit_d = 1'b0; offnd_d = 1'b0;
          bv_d = 1'b0; av_d = 1'b0; depth_d = '0;
          if (cmd_e'(cmd_i) == CMD_QUERY) begin
            ok_d = 1'b1; dside_d = side_i; dprice_d = price_i;
            state_d = S_FSCAN;
          end else begin
            state_d = S_OSCAN;
          end
        end
      end
      S_OSCAN: begin
        if (pv_q) begin
          if (ord_rdata_i.valid && ord_rdata_i.key == id_q && !hit_q) begin
            hit_d = 1'b1; oidx_d = pidx_q; oe_d = ord_rdata_i;
          end
          if (!ord_rdata_i.valid && !offnd_q) begin
            offnd_d = 1'b1; ofidx_d = pidx_q;
          end
        end
        if (scan_end) begin
          cnt_d = '0;
          lafnd_d = 1'b0; lbfnd_d = 1'b0; lffnd_d = 1'b0;
          state_d = (cmd_q != CMD_ADD && !hit_q) ? S_DECIDE : S_LSCAN;
        end
      end
      S_LSCAN: begin
        if (pv_q) begin
          if (lvl_rdata_i.valid && $signed(lvl_rdata_i.price) == price_q && !lafnd_q) begin
            lafnd_d = 1'b1; la_d = lvl_rdata_i;
            laidx_d = {lsc_side, pidx_q[LPS_AW-1:0]};
          end
          if (lvl_rdata_i.valid && $signed(lvl_rdata_i.price) == oe_q.price && !lbfnd_q) begin
            lbfnd_d = 1'b1; lb_d = lvl_rdata_i;
            lbidx_d = {lsc_side, pidx_q[LPS_AW-1:0]};
          end
          if (!lvl_rdata_i.valid && !lffnd_q) begin
            lffnd_d = 1'b1;
            lfidx_d = {lsc_side, pidx_q[LPS_AW-1:0]};
          end
        end
        if (scan_end) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        ok_d = 1'b0; uen_d = 1'b0; usa_d = 1'b0; apen_d = 1'b0;
        wa_d = 1'b0; wb_d = 1'b0; ow_d = 1'b0; owd_d = oe_q;
        dside_d = side_q; dprice_d = price_q;
        unique case (cmd_q)
          CMD_ADD: begin
            if (qty_q != '0 && !hit_q && (!lafnd_q || qty_q <= ~la_q.total) && offnd_q
                && (lafnd_q || lffnd_q)) begin
              ok_d = 1'b1; oidx_d = ofidx_q; ow_d = 1'b1; apen_d = 1'b1; wa_d = 1'b1;
              owd_d = '{valid: 1'b1, key: id_q, side: side_q, price: price_q, qty: qty_q};
              if (!lafnd_q) begin
                la_d = '{valid: 1'b1, price: price_q, total: '0, head: '0, tail: '0};
                laidx_d = lfidx_q;
              end
            end
          end
          CMD_CANCEL: begin
            if (hit_q) begin
              ok_d = 1'b1; dside_d = oe_q.side; dprice_d = oe_q.price;
              uen_d = 1'b1; wb_d = 1'b1; ow_d = 1'b1; owd_d.valid = 1'b0;
            end
          end
          CMD_MODIFY: begin
            if (hit_q) begin
              dside_d = oe_q.side;
              if (qty_q == '0) begin
                ok_d = 1'b1; uen_d = 1'b1; wb_d = 1'b1; ow_d = 1'b1; owd_d.valid = 1'b0;
              end else begin
                other = (lafnd_q ? la_q.total : 32'd0) - (same ? oe_q.qty : 32'd0);
                if (qty_q <= ~other) begin
                  if (same && lafnd_q && qty_q <= oe_q.qty) begin
                    ok_d = 1'b1; wa_d = 1'b1; ow_d = 1'b1; owd_d.qty = qty_q;
                    la_d.total = la_q.total - (oe_q.qty - qty_q);
                  end else if (lafnd_q || lffnd_q) begin
                    ok_d = 1'b1; uen_d = 1'b1; usa_d = same; wb_d = !same;
                    apen_d = 1'b1; wa_d = 1'b1; ow_d = 1'b1;
                    owd_d.price = price_q; owd_d.qty = qty_q;
                    if (!lafnd_q) begin
                      la_d = '{valid: 1'b1, price: price_q, total: '0, head: '0, tail: '0};
                      laidx_d = lfidx_q;
                    end
                  end
                end
              end
            end
          end
          default: begin
            ok_d = 1'b1;
          end
        endcase
        state_d = S_UNLINK;
      end
      S_UNLINK: begin
        if (uen_q) begin
          priority if (oidx_q == xl.head && oidx_q == xl.tail) begin
            xl.head = xl.head;
          end else if (oidx_q == xl.head) begin
            xl.head = nxt_rdata_i;
          end else if (oidx_q == xl.tail) begin
            xl.tail = prv_rdata_i;
          end else begin
            nxt_wr_o = '{we: 1'b1, addr: prv_rdata_i, data: nxt_rdata_i};
            prv_wr_o = '{we: 1'b1, addr: nxt_rdata_i, data: prv_rdata_i};
          end
          xl.total = xl.total - oe_q.qty;
          if (!usa_q && xl.total == '0) begin
            xl.valid = 1'b0;
          end
          if (usa_q) begin
            la_d = xl;
          end else begin
            lb_d = xl;
          end
        end
        state_d = S_APPEND;
      end
      S_APPEND: begin
        if (apen_q) begin
          if (la_q.total == '0) begin
            la_d.head = oidx_q;
            la_d.tail = oidx_q;
          end else begin
            nxt_wr_o = '{we: 1'b1, addr: la_q.tail, data: oidx_q};
            prv_wr_o = '{we: 1'b1, addr: oidx_q, data: la_q.tail};
            la_d.tail = oidx_q;
          end
          la_d.total = la_q.total + owd_q.qty;
        end
        state_d = S_WB_B;
      end
      S_WB_B: begin
        lvl_wr_o = '{we: wb_q, addr: lbidx_q, data: lb_q};
        ord_wr_o = '{we: ow_q, addr: oidx_q, data: owd_q};
        state_d = S_WB_A;
      end
      S_WB_A: begin
        lvl_wr_o = '{we: wa_q, addr: laidx_q, data: la_q};
        cnt_d = '0; pv_d = 1'b0;
        bv_d = 1'b0; av_d = 1'b0; depth_d = '0;
        state_d = S_FSCAN;
      end
      S_FSCAN: begin
        fidx = pidx_q[LVL_AW-1:0];
        if (pv_q && lvl_rdata_i.valid) begin
          if (!fidx[LVL_AW-1]) begin
            if (!bv_q || $signed(lvl_rdata_i.price) > bid_q) begin
              bid_d = lvl_rdata_i.price;
            end
            bv_d = 1'b1;
          end else begin
            if (!av_q || $signed(lvl_rdata_i.price) < ask_q) begin
              ask_d = lvl_rdata_i.price;
            end
            av_d = 1'b1;
          end
          if (fidx[LVL_AW-1] == dside_q && $signed(lvl_rdata_i.price) == dprice_q) begin
            depth_d = lvl_rdata_i.total;
          end
        end
        if (scan_end) begin
          state_d = S_SPREAD;
        end
      end
      S_SPREAD: begin
        pv_d = 1'b0;
        diff = {ask_q[31], ask_q} - {bid_q[31], bid_q};
        racc_d = ok_q;
        rbv_d  = bv_q;
        rav_d  = av_q;
        rbid_d = bv_q ? bid_q : 32'sd0;
        rask_d = av_q ? ask_q : 32'sd0;
        rsv_d  = bv_q && av_q && (diff[32] == diff[31]);
        rspr_d = (bv_q && av_q && (diff[32] == diff[31])) ? diff[31:0] : 32'sd0;
        rdep_d = depth_q;
        state_d = S_RESP;
      end
      S_RESP: begin
        pv_d = 1'b0;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
      pv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pv_q    <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= pidx_d;
    cmd_q <= cmd_d; id_q <= id_d; side_q <= side_d; price_q <= price_d; qty_q <= qty_d;
    hit_q <= hit_d; oidx_q <= oidx_d; oe_q <= oe_d; offnd_q <= offnd_d; ofidx_q <= ofidx_d;
    la_q <= la_d; lb_q <= lb_d; laidx_q <= laidx_d; lbidx_q <= lbidx_d; lfidx_q <= lfidx_d;
    lafnd_q <= lafnd_d; lbfnd_q <= lbfnd_d; lffnd_q <= lffnd_d;
    ok_q <= ok_d; dside_q <= dside_d; dprice_q <= dprice_d;
    uen_q <= uen_d; usa_q <= usa_d; apen_q <= apen_d;
    wa_q <= wa_d; wb_q <= wb_d; ow_q <= ow_d; owd_q <= owd_d;
    bv_q <= bv_d; av_q <= av_d; bid_q <= bid_d; ask_q <= ask_d; depth_q <= depth_d;
    racc_q <= racc_d; rbv_q <= rbv_d; rav_q <= rav_d; rsv_q <= rsv_d;
    rbid_q <= rbid_d; rask_q <= rask_d; rspr_q <= rspr_d; rdep_q <= rdep_d;
  end

  assign accepted_o     = racc_q;
  assign bid_valid_o    = rbv_q;
  assign bid_px_o       = rbid_q;
  assign ask_valid_o    = rav_q;
  assign ask_px_o       = rask_q;
  assign spread_valid_o = rsv_q;
  assign spread_ticks_o = rspr_q;
  assign level_depth_o  = rdep_q;

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// Order book table testbench
// Drives add, cancel, modify and depth query requests into the order book and
// checks results against a behavioral model of the book kept in the testbench
// or against results in the directed table, which covers field extremes
// and rejections. It is followed by random traffic over a small pool of ids
// and prices, and by a phase that fills the sell level table.
// ----------------------------------------------------------------------------
module tb;
  import ordbk_pkg::*;

  typedef struct packed {
    logic               accepted;
    logic               bid_valid;
    logic signed [31:0] bid_px;
    logic               ask_valid;
    logic signed [31:0] ask_px;
    logic               spread_valid;
    logic signed [31:0] spread_ticks;
    logic [31:0]        level_depth;
  } book_res_t;

  typedef struct packed {
    cmd_e               cmd;
    logic [31:0]        id;
    logic               side;
    logic signed [31:0] price;
    logic [31:0]        qty;
    logic               typed;
    book_res_t          res;
  } req_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [1:0]         cmd_i = CMD_QUERY;
  logic [31:0]        order_id_i = '0;
  logic               side_i = 1'b0;
  logic signed [31:0] price_i = '0;
  logic [31:0]        quantity_i = '0;
  logic               done_o;
  logic               accepted_o;
  logic               bid_valid_o;
  logic signed [31:0] bid_px_o;
  logic               ask_valid_o;
  logic signed [31:0] ask_px_o;
  logic               spread_valid_o;
  logic signed [31:0] spread_ticks_o;
  logic [31:0]        level_depth_o;

  limit_order_book_table_top DUT (.*);

  always #4 clk_i = ~clk_i;

  // Book state as the block should hold it.
  logic               ord_live [N_ORD];
  logic [31:0]        ord_id   [N_ORD];
  logic               ord_side [N_ORD];
  logic signed [31:0] ord_px   [N_ORD];
  logic [31:0]        ord_qty  [N_ORD];
  logic               lvl_live [N_LVL];
  logic signed [31:0] lvl_px   [N_LVL];
  logic [31:0]        lvl_tot  [N_LVL];

  book_res_t pending_res[$];
  int        errors = 0;
  longint    cycles = 0;

  function automatic int find_ord(logic [31:0] id);
    for (int i = 0; i < N_ORD; i++) begin
      if (ord_live[i] && ord_id[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic int find_lvl(logic side, logic signed [31:0] px);
    for (int i = 0; i < N_LPS; i++) begin
      if (lvl_live[side*N_LPS+i] && lvl_px[side*N_LPS+i] == px) return side*N_LPS + i;
    end
    return -1;
  endfunction

  function automatic int open_lvl(logic side, logic signed [31:0] px);
    for (int i = 0; i < N_LPS; i++) begin
      if (!lvl_live[side*N_LPS+i]) begin
        lvl_live[side*N_LPS+i] = 1'b1;
        lvl_px[side*N_LPS+i] = px;
        lvl_tot[side*N_LPS+i] = '0;
        return side*N_LPS + i;
      end
    end
    return -1;
  endfunction

  function automatic void pull_order(int o);
    int l;
    l = find_lvl(ord_side[o], ord_px[o]);
    if (l >= 0) begin
      lvl_tot[l] -= ord_qty[o];
      if (lvl_tot[l] == 0) lvl_live[l] = 1'b0;
    end
  endfunction

  function automatic book_res_t book_step(cmd_e cmd, logic [31:0] id, logic side,
                                          logic signed [31:0] px, logic [31:0] qty);
    book_res_t r;
    logic dside;
    int o, l, dl;
    logic same;
    logic [31:0] other;
    longint d;
    r = '0;
    dside = side;
    case (cmd)
      CMD_ADD: begin
        if (qty != 0 && find_ord(id) < 0) begin
          l = find_lvl(side, px);
          if (l < 0 || qty <= 32'hFFFF_FFFF - lvl_tot[l]) begin
            o = -1;
            for (int i = 0; i < N_ORD; i++) begin
              if (!ord_live[i] && o < 0) o = i;
            end
            if (o >= 0 && l < 0) l = open_lvl(side, px);
            if (o >= 0 && l >= 0) begin
              ord_live[o] = 1'b1;
              ord_id[o] = id;
              ord_side[o] = side;
              ord_px[o] = px;
              ord_qty[o] = qty;
              lvl_tot[l] += qty;
              r.accepted = 1'b1;
            end
          end
        end
      end
      CMD_CANCEL: begin
        o = find_ord(id);
        if (o >= 0) begin
          dside = ord_side[o];
          px = ord_px[o];
          pull_order(o);
          ord_live[o] = 1'b0;
          r.accepted = 1'b1;
        end
      end
      CMD_MODIFY: begin
        o = find_ord(id);
        if (o >= 0) begin
          dside = ord_side[o];
          if (qty == 0) begin
            pull_order(o);
            ord_live[o] = 1'b0;
            r.accepted = 1'b1;
          end else begin
            same = (px == ord_px[o]);
            l = find_lvl(dside, px);
            other = (l >= 0 ? lvl_tot[l] : 32'd0) - (same ? ord_qty[o] : 32'd0);
            if (qty <= 32'hFFFF_FFFF - other) begin
              if (same && l >= 0 && qty <= ord_qty[o]) begin
                lvl_tot[l] -= ord_qty[o] - qty;
                ord_qty[o] = qty;
                r.accepted = 1'b1;
              end else begin
                if (l < 0) l = open_lvl(dside, px);
                if (l >= 0) begin
                  if (same) lvl_tot[l] -= ord_qty[o];
                  else pull_order(o);
                  ord_px[o] = px;
                  ord_qty[o] = qty;
                  lvl_tot[l] += qty;
                  r.accepted = 1'b1;
                end
              end
            end
          end
        end
      end
      default: r.accepted = 1'b1;
    endcase
    for (int i = 0; i < N_LPS; i++) begin
      if (lvl_live[i] && (!r.bid_valid || lvl_px[i] > r.bid_px)) begin
        r.bid_px = lvl_px[i];
        r.bid_valid = 1'b1;
      end
      if (lvl_live[N_LPS+i] && (!r.ask_valid || lvl_px[N_LPS+i] < r.ask_px)) begin
        r.ask_px = lvl_px[N_LPS+i];
        r.ask_valid = 1'b1;
      end
    end
    if (r.bid_valid && r.ask_valid) begin
      d = longint'(r.ask_px) - longint'(r.bid_px);
      if (d >= -64'sd2147483648 && d <= 64'sd2147483647) begin
        r.spread_valid = 1'b1;
        r.spread_ticks = d[31:0];
      end
    end
    dl = find_lvl(dside, px);
    r.level_depth = dl >= 0 ? lvl_tot[dl] : 32'd0;
    return r;
  endfunction

  // Issues one request after a gap and returns once the block has taken it.
  task automatic issue(int gap, cmd_e cmd, logic [31:0] id, logic side,
                       logic signed [31:0] px, logic [31:0] qty,
                       logic typed = 1'b0, book_res_t want = '0);
    book_res_t r;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    cmd_i <= cmd;
    order_id_i <= id;
    side_i <= side;
    price_i <= px;
    quantity_i <= qty;
    do @(posedge clk_i); while (busy_o);
    r = book_step(cmd, id, side, px, qty);
    pending_res.push_back(typed ? want : r);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    book_res_t w;
    cycles++;
    if (cycles > 40_000_000) begin
      $display("tb NOT OK");
      $finish;
    end
    if (rst_ni && done_o) begin
      if (pending_res.size() == 0) begin
        $display("%0t: result with no request outstanding", $time);
        errors++;
      end else begin
        w = pending_res.pop_front();
        check_field("accepted", w.accepted, accepted_o);
        check_field("bid_valid", w.bid_valid, bid_valid_o);
        check_field("bid_px", w.bid_px, bid_px_o);
        check_field("ask_valid", w.ask_valid, ask_valid_o);
        check_field("ask_px", w.ask_px, ask_px_o);
        check_field("spread_valid", w.spread_valid, spread_valid_o);
        check_field("spread_ticks", w.spread_ticks, spread_ticks_o);
        check_field("level_depth", w.level_depth, level_depth_o);
      end
    end
  end

  function automatic logic [31:0] pick_id();
    if ($urandom_range(0, 15) == 0) return $urandom();
    return $urandom_range(0, 47) * 32'h9E37_79B1;
  endfunction

  function automatic logic signed [31:0] pick_px();
    case ($urandom_range(0, 19))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $urandom();
      default: return $signed($urandom_range(0, 16)) - 8;
    endcase
  endfunction

  function automatic logic [31:0] pick_qty();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      3: return 32'hFFFF_FFFF - $urandom_range(0, 40);
      default: return $urandom_range(1, 100);
    endcase
  endfunction

  req_row_t dir_rows[$] = '{
    '{CMD_QUERY,  32'd0,        1'b0, 32'sd0,         32'd0,        1'b1,
      book_res_t'{1'b1, 1'b0, 32'sd0, 1'b0, 32'sd0, 1'b0, 32'sd0, 32'd0}},
    '{CMD_ADD,    32'd0,        1'b0, 32'sd0,         32'd0,        1'b1, '0},
    '{CMD_CANCEL, 32'hFFFF_FFFF, 1'b1, 32'sd0,        32'd1,        1'b1, '0},
    '{CMD_MODIFY, 32'hFFFF_FFFF, 1'b1, -32'sd1,       32'd5,        1'b1, '0},
    '{CMD_ADD,    32'd1,        1'b0, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
    '{CMD_ADD,    32'd2,        1'b1, 32'sh8000_0000, 32'd1,        1'b0, '0},
    '{CMD_ADD,    32'd3,        1'b0, 32'sh7FFF_FFFF, 32'd1,        1'b0, '0},
    '{CMD_ADD,    32'd1,        1'b1, 32'sd7,         32'd1,        1'b0, '0},
    '{CMD_ADD,    32'd4,        1'b1, 32'sd100,       32'd5,        1'b0, '0},
    '{CMD_ADD,    32'd5,        1'b1, 32'sd100,       32'd7,        1'b0, '0},
    '{CMD_MODIFY, 32'd4,        1'b0, 32'sd100,       32'd3,        1'b0, '0},
    '{CMD_MODIFY, 32'd4,        1'b1, 32'sd100,       32'd9,        1'b0, '0},
    '{CMD_MODIFY, 32'd5,        1'b0, 32'sd101,       32'd7,        1'b0, '0},
    '{CMD_MODIFY, 32'd2,        1'b1, 32'sd0,         32'd0,        1'b0, '0},
    '{CMD_ADD,    32'd6,        1'b0, 32'sd50,        32'hFFFF_FFF0, 1'b0, '0},
    '{CMD_ADD,    32'd7,        1'b0, 32'sd50,        32'd15,       1'b0, '0},
    '{CMD_MODIFY, 32'd7,        1'b0, 32'sd50,        32'd16,       1'b0, '0},
    '{CMD_ADD,    32'hFFFF_FFFF, 1'b1, 32'sh8000_0000, 32'd2,       1'b0, '0},
    '{CMD_QUERY,  32'd0,        1'b1, 32'sd101,       32'd0,        1'b0, '0},
    '{CMD_QUERY,  32'hFFFF_FFFF, 1'b0, 32'sd50,       32'hFFFF_FFFF, 1'b0, '0},
    '{CMD_CANCEL, 32'd1,        1'b0, 32'sd0,         32'd0,        1'b0, '0},
    '{CMD_CANCEL, 32'd6,        1'b1, 32'sd0,         32'd0,        1'b0, '0},
    '{CMD_CANCEL, 32'hFFFF_FFFF, 1'b0, 32'sd0,        32'd0,        1'b0, '0},
    '{CMD_MODIFY, 32'd4,        1'b0, 32'sh7FFF_FFFF, 32'hFFFF_FFF7, 1'b0, '0}
  };

  initial begin
    cmd_e c;
    int gap;
    int k;
    int o;
    for (int i = 0; i < N_ORD; i++) ord_live[i] = 1'b0;
    for (int i = 0; i < N_LVL; i++) lvl_live[i] = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (dir_rows[i]) begin
      issue($urandom_range(0, 3), dir_rows[i].cmd, dir_rows[i].id, dir_rows[i].side,
            dir_rows[i].price, dir_rows[i].qty, dir_rows[i].typed, dir_rows[i].res);
    end
    for (int i = 0; i < 600; i++) begin
      gap = ((i / 64) % 3 == 0) ? 0 : $urandom_range(0, 17);
      if (i == 300) begin
        start_i <= 1'b0;
        while (pending_res.size() != 0) @(posedge clk_i);
        gap = 1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: c = CMD_ADD;
        4, 5:       c = CMD_CANCEL;
        6, 7, 8:    c = CMD_MODIFY;
        default:    c = CMD_QUERY;
      endcase
      issue(gap, c, pick_id(), $urandom_range(0, 1), pick_px(), pick_qty());
    end
    // Fill the sell level table so that further new sell levels are refused.
    k = 0;
    while (k < 300) begin
      issue($urandom_range(0, 2), CMD_ADD, 32'h8000_0000 + k, 1'b1, 32'sd1000 + k,
            32'd1 + k % 3);
      k++;
    end
    issue(2, CMD_ADD, 32'h7000_0000, 1'b0, 32'sd3, 32'd1);
    o = 0;
    while (o < N_ORD - 1 && !(ord_live[o] && ord_side[o])) o++;
    issue(2, CMD_MODIFY, ord_id[o], 1'b0, 32'sd5000, 32'd4);
    issue(2, CMD_QUERY, 32'd0, 1'b1, 32'sd1000, 32'd0);
    start_i <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/ordbk_pkg.sv
sv/ordbk_store.sv
sv/ordbk_ctrl.sv
sv/limit_order_book_table_top.sv
dv/tb.sv
